// ===== design/onewire_thermometer_sequencer_top_defines.svh =====
// Assertion macros shared by the one-wire thermometer sequencer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ONEWIRE_THERMOMETER_SEQUENCER_TOP_DEFINES_SVH
`define ONEWIRE_THERMOMETER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ows_pkg.sv =====
// Types and constants of the one-wire thermometer sequencer.
// Depends on nothing; used by ows_ctrl, ows_datapath and the top module.
package ows_pkg;

    typedef enum logic [3:0] {
        SQ_RESET1  = 4'd0,
        SQ_SKIP1   = 4'd1,
        SQ_CONVERT = 4'd2,
        SQ_RESET2  = 4'd3,
        SQ_SKIP2   = 4'd4,
        SQ_READSP  = 4'd5,
        SQ_RDLO    = 4'd6,
        SQ_RDHI    = 4'd7,
        SQ_HELD    = 4'd8,
        SQ_RESTART = 4'd9
    } seq_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_FINISH,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD = 3'd0,
        REG_DISCARD_COUNT = 3'd1,
        REG_LOW_LIMIT     = 3'd2,
        REG_HIGH_LIMIT    = 3'd3,
        REG_FAIL_LIMIT    = 3'd4
    } cfg_reg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 24;
    localparam int TEMP_W     = 16;

    localparam logic [7:0] OW_SKIP_ROM = 8'hCC;
    localparam logic [7:0] OW_CONVERT  = 8'h44;
    localparam logic [7:0] OW_READ_SP  = 8'hBE;
    localparam logic [7:0] OW_MSB_SET  = 8'h80;

    localparam logic [23:0] D_RESET_HIGH = 24'd10000;
    localparam logic [23:0] D_RESET_LOW  = 24'd600;
    localparam logic [23:0] D_PRES_WAIT  = 24'd65;
    localparam logic [23:0] D_PRES_TAIL  = 24'd480;
    localparam logic [23:0] D_SLOT_EDGE  = 24'd10;
    localparam logic [23:0] D_SLOT_BIT   = 24'd60;
    localparam logic [23:0] D_READ_LOW   = 24'd1;
    localparam logic [23:0] D_SHORT      = 24'd2000;
    localparam logic [23:0] D_REJECT     = 24'd10000;
    localparam logic [23:0] D_RETRY      = 24'd50000;
    localparam logic [9:0]  US_PER_MS    = 10'd1000;

    typedef struct packed {
        logic step_en;
        logic sort_en;
        logic finish_en;
    } dp_cmd_t;

    typedef struct packed {
        logic start_sort;
        logic sort_last;
    } dp_status_t;

endpackage

// ===== design/ows_in_if.sv =====
// Input channel of the sequencer: timer tick or host take, with line level.
// Depends on nothing.
interface ows_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic line_level;
    modport source (output valid, output cmd, output line_level, input ready);
    modport sink (input valid, input cmd, input line_level, output ready);
endinterface

// ===== design/ows_out_if.sv =====
// Output channel of the sequencer: line drive, delay and held median.
// Depends on nothing.
interface ows_out_if;
    logic        valid;
    logic        ready;
    logic        drive_enable;
    logic        drive_level;
    logic [23:0] delay_us;
    logic        result_ready;
    logic signed [15:0] temperature;
    logic        sensor_failed;
    modport source (output valid, output drive_enable, output drive_level, output delay_us,
                    output result_ready, output temperature, output sensor_failed,
                    input ready);
    modport sink (input valid, input drive_enable, input drive_level, input delay_us,
                  input result_ready, input temperature, input sensor_failed,
                  output ready);
endinterface

// ===== design/ows_ctrl.sv =====
// Controller of the sequencer: accepts beats, runs the median sort, hands out results.
// Depends on ows_pkg and the assertion macro header.
`include "onewire_thermometer_sequencer_top_defines.svh"

module ows_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ows_pkg::dp_status_t status,
    output ows_pkg::dp_cmd_t    cmd
);

    ows_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ows_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.step_en   = 1'b0;
        cmd.sort_en   = 1'b0;
        cmd.finish_en = 1'b0;
        unique case (state_reg)
            ows_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step_en = 1'b1;
                    state_next  = status.start_sort ? ows_pkg::ST_SORT : ows_pkg::ST_OUT;
                end
            end
            ows_pkg::ST_SORT:
            begin
                cmd.sort_en = 1'b1;
                if (status.sort_last)
                begin
                    state_next = ows_pkg::ST_FINISH;
                end
            end
            ows_pkg::ST_FINISH:
            begin
                cmd.finish_en = 1'b1;
                state_next    = ows_pkg::ST_OUT;
            end
            ows_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ows_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ows_pkg::ST_IDLE;
            end
        endcase
    end

    `OWS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != ows_pkg::ST_IDLE, "accepted beat did not start work")
    `OWS_ASSERT_NEXT(a_sort_ends, state_reg == ows_pkg::ST_SORT && status.sort_last, state_reg == ows_pkg::ST_FINISH, "sort did not finish")
    `OWS_ASSERT_NEXT(a_finish_to_out, cmd.finish_en, out_valid, "median not presented after finish")
    `OWS_ASSERT_NOW(a_one_cmd, 1'b1, !(cmd.step_en && (cmd.sort_en || cmd.finish_en)), "overlapping datapath commands")

endmodule

// ===== design/ows_datapath.sv =====
// Datapath of the sequencer: bus phase rules, counters, reading store and sorter.
// Depends on ows_pkg.
module ows_datapath #(
    parameter int MEDIAN_DEPTH = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ows_pkg::dp_cmd_t    cmd,
    output ows_pkg::dp_status_t status,
    input  logic                in_cmd,
    input  logic                in_line,
    input  logic                cfg_we,
    input  logic [ows_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ows_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                drive_enable,
    output logic                drive_level,
    output logic [ows_pkg::DELAY_W-1:0] delay_us,
    output logic                result_ready,
    output logic signed [ows_pkg::TEMP_W-1:0] temperature,
    output logic                sensor_failed
);

    localparam int CNT_W   = $clog2(MEDIAN_DEPTH + 1);
    localparam int IDX_W   = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
    localparam int MID_HI  = MEDIAN_DEPTH / 2;
    localparam int MID_LO  = (MEDIAN_DEPTH > 1) ? MEDIAN_DEPTH / 2 - 1 : 0;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MEDIAN_DEPTH);

    logic [13:0] period_reg;
    logic [7:0]  discard_limit_reg;
    logic signed [15:0] low_limit_reg;
    logic signed [15:0] high_limit_reg;
    logic [7:0]  fail_limit_reg;

    ows_pkg::seq_t seq_reg, seq_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] disc_reg, disc_next;
    logic [7:0] fail_reg, fail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pass_reg;
    logic signed [15:0] held_reg;
    logic signed [15:0] store_reg [MEDIAN_DEPTH];

    logic        en, lvl, failed, rdy, wr, start_sort;
    logic [23:0] d;
    logic [2:0]  ph;
    logic [3:0]  bc;
    logic [7:0]  code, sb;
    logic [8:0]  f;
    logic [13:0] per;
    logic signed [15:0] raw;
    logic signed [16:0] mid_sum;
    logic signed [15:0] median;

    assign raw = {shift_reg, low_reg};

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        low_next   = low_reg;
        disc_next  = disc_reg;
        fail_next  = fail_reg;
        cnt_next   = cnt_reg;
        en         = 1'b1;
        lvl        = 1'b1;
        d          = ows_pkg::D_SHORT;
        failed     = 1'b0;
        wr         = 1'b0;
        start_sort = 1'b0;
        ph         = (phase_reg > 3'd4) ? 3'd0 : phase_reg;
        bc         = 4'd0;
        code       = ows_pkg::OW_SKIP_ROM;
        sb         = 8'd0;
        f          = {1'b0, fail_reg} + 9'd1;
        per        = (period_reg == 14'd0) ? 14'd1 : period_reg;
        if (in_cmd)
        begin
            en  = 1'b0;
            lvl = 1'b0;
            d   = '0;
            if (seq_reg == ows_pkg::SQ_HELD)
            begin
                seq_next = ows_pkg::SQ_RESTART;
            end
        end
        else
        begin
            case (seq_reg)
                ows_pkg::SQ_RESET1, ows_pkg::SQ_RESET2:
                begin
                    case (ph)
                        3'd0:
                        begin
                            d = ows_pkg::D_RESET_HIGH;
                            phase_next = 3'd1;
                        end
                        3'd1:
                        begin
                            lvl = 1'b0;
                            d = ows_pkg::D_RESET_LOW;
                            phase_next = 3'd2;
                        end
                        3'd2:
                        begin
                            en = 1'b0;
                            d = ows_pkg::D_PRES_WAIT;
                            phase_next = 3'd3;
                        end
                        3'd3:
                        begin
                            if (!in_line)
                            begin
                                en = 1'b0;
                                d = ows_pkg::D_PRES_TAIL;
                                phase_next = 3'd4;
                            end
                            else
                            begin
                                d = ows_pkg::D_RETRY;
                                if (f > {1'b0, fail_limit_reg})
                                begin
                                    failed = 1'b1;
                                    fail_next = 8'd0;
                                end
                                else
                                begin
                                    fail_next = f[7:0];
                                end
                                seq_next   = ows_pkg::SQ_RESET1;
                                phase_next = 3'd0;
                                bit_next   = 4'd0;
                                disc_next  = 8'd0;
                                cnt_next   = '0;
                            end
                        end
                        default:
                        begin
                            d = ows_pkg::D_SLOT_EDGE;
                            phase_next = 3'd0;
                            bit_next   = 4'd0;
                            fail_next  = 8'd0;
                            seq_next   = (seq_reg == ows_pkg::SQ_RESET1) ?
                                         ows_pkg::SQ_SKIP1 : ows_pkg::SQ_SKIP2;
                        end
                    endcase
                end
                ows_pkg::SQ_SKIP1, ows_pkg::SQ_CONVERT, ows_pkg::SQ_SKIP2, ows_pkg::SQ_READSP:
                begin
                    code = (seq_reg == ows_pkg::SQ_CONVERT) ? ows_pkg::OW_CONVERT :
                           (seq_reg == ows_pkg::SQ_READSP) ? ows_pkg::OW_READ_SP :
                           ows_pkg::OW_SKIP_ROM;
                    bc = (bit_reg > 4'd2) ? 4'd0 : bit_reg;
                    if (bc == 4'd0)
                    begin
                        lvl = 1'b0;
                        d = ows_pkg::D_SLOT_EDGE;
                        bit_next = 4'd1;
                    end
                    else if (bc == 4'd1)
                    begin
                        lvl = code[phase_reg];
                        d = ows_pkg::D_SLOT_BIT;
                        bit_next = 4'd2;
                    end
                    else
                    begin
                        d = ows_pkg::D_SLOT_EDGE;
                        bit_next = 4'd0;
                        if (phase_reg == 3'd7)
                        begin
                            phase_next = 3'd0;
                            seq_next = (seq_reg == ows_pkg::SQ_SKIP1) ? ows_pkg::SQ_CONVERT :
                                       (seq_reg == ows_pkg::SQ_CONVERT) ? ows_pkg::SQ_RESET2 :
                                       (seq_reg == ows_pkg::SQ_SKIP2) ? ows_pkg::SQ_READSP :
                                       ows_pkg::SQ_RDLO;
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                end
                ows_pkg::SQ_RDLO, ows_pkg::SQ_RDHI:
                begin
                    bc = (bit_reg > 4'd3) ? 4'd0 : bit_reg;
                    if (bc == 4'd0)
                    begin
                        sb = (phase_reg == 3'd0) ? 8'd0 : shift_reg;
                        shift_next = sb >> 1;
                        lvl = 1'b0;
                        d = ows_pkg::D_READ_LOW;
                        bit_next = 4'd1;
                    end
                    else if (bc == 4'd1)
                    begin
                        en = 1'b0;
                        d = ows_pkg::D_SLOT_EDGE;
                        bit_next = 4'd2;
                    end
                    else if (bc == 4'd2)
                    begin
                        if (in_line)
                        begin
                            shift_next = shift_reg | ows_pkg::OW_MSB_SET;
                        end
                        en = 1'b0;
                        d = ows_pkg::D_SLOT_BIT;
                        bit_next = 4'd3;
                    end
                    else
                    begin
                        d = ows_pkg::D_SLOT_EDGE;
                        bit_next = 4'd0;
                        if (phase_reg == 3'd7)
                        begin
                            phase_next = 3'd0;
                            if (seq_reg == ows_pkg::SQ_RDLO)
                            begin
                                low_next = shift_reg;
                                seq_next = ows_pkg::SQ_RDHI;
                            end
                            else if (disc_reg >= discard_limit_reg && raw > low_limit_reg
                                     && raw < high_limit_reg)
                            begin
                                wr = 1'b1;
                                d  = ows_pkg::D_SHORT;
                                if (cnt_reg + CNT_W'(1) >= DEPTH_C)
                                begin
                                    cnt_next   = '0;
                                    seq_next   = ows_pkg::SQ_HELD;
                                    start_sort = 1'b1;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + CNT_W'(1);
                                    seq_next = ows_pkg::SQ_RESTART;
                                end
                            end
                            else
                            begin
                                if (discard_limit_reg != 8'd0 && disc_reg != 8'd255)
                                begin
                                    disc_next = disc_reg + 8'd1;
                                end
                                seq_next = ows_pkg::SQ_RESTART;
                                d = ows_pkg::D_REJECT;
                            end
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                end
                ows_pkg::SQ_HELD:
                begin
                    d = ows_pkg::D_SHORT;
                end
                ows_pkg::SQ_RESTART:
                begin
                    if (disc_reg < discard_limit_reg || cnt_reg != '0)
                    begin
                        d = ows_pkg::D_SHORT;
                    end
                    else
                    begin
                        d = 24'(per) * 24'(ows_pkg::US_PER_MS);
                    end
                    seq_next   = ows_pkg::SQ_RESET1;
                    phase_next = 3'd0;
                    bit_next   = 4'd0;
                end
                default:
                begin
                    d = ows_pkg::D_RETRY;
                    seq_next   = ows_pkg::SQ_RESET1;
                    phase_next = 3'd0;
                    bit_next   = 4'd0;
                end
            endcase
        end
        rdy = in_cmd ? (seq_reg == ows_pkg::SQ_HELD) : (seq_next == ows_pkg::SQ_HELD);
    end

    assign status.start_sort = start_sort;
    assign status.sort_last  = (pass_reg >= DEPTH_C - CNT_W'(1));

    assign mid_sum = 17'(store_reg[MID_HI]) + 17'(store_reg[MID_LO]);
    assign median  = (MEDIAN_DEPTH % 2 == 1) ? store_reg[MID_HI] : mid_sum[16:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg        <= 14'd500;
            discard_limit_reg <= 8'd20;
            low_limit_reg     <= -16'sd880;
            high_limit_reg    <= 16'sd2000;
            fail_limit_reg    <= 8'd5;
            seq_reg           <= ows_pkg::SQ_RESET1;
            phase_reg         <= '0;
            bit_reg           <= '0;
            shift_reg         <= '0;
            low_reg           <= '0;
            disc_reg          <= '0;
            fail_reg          <= '0;
            cnt_reg           <= '0;
            pass_reg          <= '0;
            held_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ows_pkg::REG_SAMPLE_PERIOD: period_reg        <= cfg_data[13:0];
                    ows_pkg::REG_DISCARD_COUNT: discard_limit_reg <= cfg_data[7:0];
                    ows_pkg::REG_LOW_LIMIT:     low_limit_reg     <= cfg_data;
                    ows_pkg::REG_HIGH_LIMIT:    high_limit_reg    <= cfg_data;
                    ows_pkg::REG_FAIL_LIMIT:    fail_limit_reg    <= cfg_data[7:0];
                    default:                    ;
                endcase
            end
            if (cmd.step_en)
            begin
                seq_reg   <= seq_next;
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                low_reg   <= low_next;
                disc_reg  <= disc_next;
                fail_reg  <= fail_next;
                cnt_reg   <= cnt_next;
                pass_reg  <= '0;
            end
            if (cmd.sort_en)
            begin
                pass_reg <= pass_reg + CNT_W'(1);
            end
            if (cmd.finish_en)
            begin
                held_reg <= median;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_en && wr)
        begin
            store_reg[cnt_reg[IDX_W-1:0]] <= raw;
        end
        else if (cmd.sort_en)
        begin
            for (int i = 0; i + 1 < MEDIAN_DEPTH; i++)
            begin
                if ((i % 2) == int'(pass_reg[0]) && store_reg[i] > store_reg[i + 1])
                begin
                    store_reg[i]     <= store_reg[i + 1];
                    store_reg[i + 1] <= store_reg[i];
                end
            end
        end
        if (cmd.step_en)
        begin
            drive_enable  <= en;
            drive_level   <= en & lvl;
            delay_us      <= d;
            result_ready  <= rdy;
            temperature   <= rdy ? held_reg : 16'sd0;
            sensor_failed <= failed;
        end
        else if (cmd.finish_en)
        begin
            temperature <= median;
        end
    end

endmodule

// ===== design/onewire_thermometer_sequencer_top.sv =====
// One-wire thermometer sequencer: each input beat is a phase-timer tick carrying the
// sampled line level, or a host take of the held median; each beat yields one output beat
// with the line drive, the delay to the next tick and the held median. The result is
// offered the cycle after its beat is accepted, or, when the reading completes the store,
// after the sort and finish states, in which the odd-even transposition sorter runs one pass
// per cycle over the store. The input is ready again the cycle after the result is taken.
// One beat is in flight at a time. Depends on ows_pkg, ows_in_if, ows_out_if, ows_ctrl
// and ows_datapath.
module onewire_thermometer_sequencer_top #(
    parameter int MEDIAN_DEPTH = 9
) (
    input  logic clk,
    input  logic rst_n,
    ows_in_if.sink     in_ch,
    ows_out_if.source  out_ch,
    input  logic                               cfg_we,
    input  logic [ows_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ows_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ows_pkg::dp_cmd_t    cmd;
    ows_pkg::dp_status_t status;

    ows_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ows_datapath #(
        .MEDIAN_DEPTH (MEDIAN_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_cmd        (in_ch.cmd),
        .in_line       (in_ch.line_level),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .drive_enable  (out_ch.drive_enable),
        .drive_level   (out_ch.drive_level),
        .delay_us      (out_ch.delay_us),
        .result_ready  (out_ch.result_ready),
        .temperature   (out_ch.temperature),
        .sensor_failed (out_ch.sensor_failed)
    );

endmodule
